FILE: design/sth_pkg.sv
// shared types, codes and constants of the synchronized trapezoid homing block
package sth_pkg;

	typedef enum logic [2:0] {
		KIND_FEEDBACK = 3'd0,
		KIND_HOME     = 3'd1,
		KIND_TICK     = 3'd2,
		KIND_START    = 3'd3,
		KIND_STOP     = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RUN  = 2'd1,
		MODE_STOP = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		REG_JOINT_COUNT = 2'd0,
		REG_SPEED_LIMIT = 2'd1,
		REG_ACCEL_LIMIT = 2'd2
	} reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_P1_DIFF,
		ST_P1_MDA,
		ST_P1_MVV,
		ST_P1_MAV,
		ST_P1_CMP,
		ST_P1_TRI_DIV,
		ST_P1_SQRT,
		ST_P1_RAMP_DIV,
		ST_P1_COAST_DIV,
		ST_P1_BEST,
		ST_P1_END,
		ST_P1_DEN,
		ST_P2_DIFF,
		ST_P2_DIV,
		ST_P2_WAIT,
		ST_P2_END,
		ST_ADV,
		ST_F1,
		ST_F2,
		ST_F3,
		ST_OUT_PREP,
		ST_PM1,
		ST_PM2,
		ST_PM3,
		ST_OUT
	} state_t;

	// request to the shared divider: floor(numer * 2^shift / denom), capped
	typedef struct packed {
		logic        start;
		logic [5:0]  shift;
		logic [63:0] numer;
		logic [63:0] denom;
		logic [63:0] cap;
	} div_req_t;

	localparam logic [3:0]  JOINT_COUNT_RST = 4'd8;
	localparam logic [30:0] SPEED_LIMIT_RST = 31'd32768;
	localparam logic [30:0] ACCEL_LIMIT_RST = 31'd32768;

	localparam logic [63:0] DENOM_MIN = 64'd43;
	localparam logic [63:0] CAP_U64   = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] CAP_U32   = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] CAP_S31   = 64'h0000_0000_7FFF_FFFF;
	localparam logic [5:0]  SHIFT_Q16 = 6'd16;
	localparam logic [5:0]  SHIFT_Q32 = 6'd32;

	// saturate a product to 64 bits
	function automatic logic [63:0] sat64(input logic [66:0] p);
		logic [63:0] r;
		r = (p[66:64] != 3'd0) ? CAP_U64 : p[63:0];
		return r;
	endfunction

endpackage

FILE: design/synced_trapezoid_homing_top.sv
// top level: homing trajectory generator with shared multiplier, divider and root unit
//
// Input channel (in_valid/in_stall) takes one transaction per item: feedback or home
// position writes, start, stop, or a tick that advances time by tick_time.
// Writes, start and stop complete without stalling the channel, and the next item is taken right after.
// A tick while running emits one result per joint in use on out_valid/out_stall,
// out_joint counting up from 0 and last marking the final joint.
// The first tick after start plans the move: per joint three 64-bit products, then
// two 96-step divisions, or one division and a 32-step root; then one acceleration
// division per joint unless the denominator is below DENOM_MIN, all through one
// shared multiplier and one shared bit-serial divider. Later ticks while moving
// evaluate the profile and scale it per joint; in hold results go out directly.
// in_stall stays high from a tick's acceptance until its last result is taken; a
// stalled result holds its payload, and the sequencer waits without losing anything.
// Configuration writes (cfg_we) must only be made while idle, not enforced here.
// Reset clears the run state, limits to their defaults, feedback, start positions and
// accelerations; home positions have no reset and must be written before a move.
module synced_trapezoid_homing_top #(
	parameter int JOINTS_MAX = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         kind,
	input  logic [2:0]         joint,
	input  logic signed [31:0] position,
	input  logic [16:0]        tick_time,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         out_joint,
	output logic signed [31:0] target_position,
	output logic               last
);

	localparam int JW = $clog2(JOINTS_MAX + 1);
	localparam int IW = (JOINTS_MAX > 1) ? $clog2(JOINTS_MAX) : 1;
	localparam int CW = (JW > 4) ? JW : 4;

	sth_pkg::state_t state_q, state_d;
	sth_pkg::mode_t  mode_q;

	logic [3:0]  jcnt_q;
	logic [30:0] vlim_q, alim_q;

	logic        moving_q, holding_q, done_q;
	logic [31:0] elapsed_q, ramp_time_q, coast_time_q, total_q;
	logic [16:0] dt_q;
	logic [JW-1:0] j_q;

	logic signed [31:0] start_pos_q [JOINTS_MAX];
	logic signed [31:0] accel_q     [JOINTS_MAX];
	logic signed [31:0] fb_q        [JOINTS_MAX];
	logic signed [31:0] home_q      [JOINTS_MAX];

	logic signed [32:0] diff_q;
	logic [63:0] da_q, vv_q, av_q, denom_q, f2_q, plo_q;
	logic [31:0] ramp_q, coast_q, best_ramp_q, best_coast_q;
	logic [33:0] best_q;

	logic [2:0]         out_joint_q;
	logic signed [31:0] out_target_q;
	logic               out_last_q;

	logic [31:0] mul_a;
	logic [34:0] mul_b;
	logic [66:0] prod_q;

	sth_pkg::div_req_t div_req;
	logic        div_done;
	logic [63:0] div_quot;
	logic        sq_start;
	logic [63:0] sq_val;
	logic        sq_done;
	logic [31:0] sq_root;

	// derived values
	logic [JW-1:0] n_act;
	logic [CW-1:0] jcnt_ext;
	logic [IW-1:0] jidx, widx;
	logic          in_acc, tick_run, plan_now, joint_ok, j_end, last_j;
	logic [30:0]   v_eff, a_eff;
	logic [31:0]   d_abs;
	logic [33:0]   local_t;
	logic [32:0]   t_next, t2;
	logic          over;
	logic          in_a, in_b;
	logic [32:0]   td_w;
	logic [31:0]   td;
	logic signed [31:0] acc_sel;
	logic [31:0]   mag;
	logic [64:0]   low_sum;
	logic [63:0]   off;
	logic signed [65:0] sum;
	logic signed [31:0] clamped;

	assign jcnt_ext = CW'(jcnt_q);
	assign n_act    = (jcnt_ext < CW'(JOINTS_MAX)) ? JW'(jcnt_ext) : JW'(JOINTS_MAX);
	assign jidx     = j_q[IW-1:0];
	assign widx     = IW'(joint);
	assign joint_ok = int'(joint) < JOINTS_MAX;
	assign j_end    = j_q == n_act;
	assign last_j   = (j_q + 1'b1) == n_act;
	assign in_acc   = in_valid && !in_stall;
	assign tick_run = (sth_pkg::kind_t'(kind) == sth_pkg::KIND_TICK) &&
	                  (mode_q == sth_pkg::MODE_RUN);
	assign plan_now = !moving_q && !holding_q;

	assign v_eff = (vlim_q == '0) ? 31'd1 : vlim_q;
	assign a_eff = (alim_q == '0) ? 31'd1 : alim_q;
	assign d_abs = diff_q[32] ? 32'(-diff_q) : diff_q[31:0];
	assign local_t = 34'({ramp_q, 1'b0}) + 34'(coast_q);

	assign t_next = 33'(elapsed_q) + 33'(dt_q);
	assign over   = t_next > 33'(total_q);

	// profile segment for the current elapsed time
	assign t2   = 33'(ramp_time_q) + 33'(coast_time_q);
	assign in_a = elapsed_q <= ramp_time_q;
	assign in_b = 33'(elapsed_q) <= t2;
	assign td_w = 33'(elapsed_q) - t2;
	assign td   = td_w[31:0];

	assign acc_sel = accel_q[jidx];
	assign mag     = acc_sel[31] ? 32'(-acc_sel) : acc_sel;
	assign low_sum = 65'({prod_q[0], 32'd0}) + 65'(plo_q);
	assign off     = (prod_q[63:0] >> 1) + 64'(low_sum >> 33);
	assign sum     = acc_sel[31] ? (66'(start_pos_q[jidx]) - $signed({2'b00, off}))
	                             : (66'(start_pos_q[jidx]) + $signed({2'b00, off}));
	always_comb begin
		if (!sum[65] && (sum[64:31] != '0)) begin
			clamped = 32'sh7FFF_FFFF;
		end else if (sum[65] && (sum[64:31] != '1)) begin
			clamped = 32'sh8000_0000;
		end else begin
			clamped = sum[31:0];
		end
	end

	sth_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	sth_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_val),
		.done     (sq_done),
		.root     (sq_root)
	);

	// shared multiplier, product registered
	always_ff @(posedge clk) begin
		prod_q <= 67'(mul_a) * 67'(mul_b);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sth_pkg::ST_IDLE: begin
				if (in_acc && tick_run) begin
					state_d = plan_now ? sth_pkg::ST_P1_DIFF : sth_pkg::ST_ADV;
				end
			end
			sth_pkg::ST_P1_DIFF: state_d = j_end ? sth_pkg::ST_P1_END : sth_pkg::ST_P1_MDA;
			sth_pkg::ST_P1_MDA: state_d = sth_pkg::ST_P1_MVV;
			sth_pkg::ST_P1_MVV: state_d = sth_pkg::ST_P1_MAV;
			sth_pkg::ST_P1_MAV: state_d = sth_pkg::ST_P1_CMP;
			sth_pkg::ST_P1_CMP: begin
				state_d = (da_q < vv_q) ? sth_pkg::ST_P1_TRI_DIV : sth_pkg::ST_P1_RAMP_DIV;
			end
			sth_pkg::ST_P1_TRI_DIV: if (div_done) state_d = sth_pkg::ST_P1_SQRT;
			sth_pkg::ST_P1_SQRT: if (sq_done) state_d = sth_pkg::ST_P1_BEST;
			sth_pkg::ST_P1_RAMP_DIV: if (div_done) state_d = sth_pkg::ST_P1_COAST_DIV;
			sth_pkg::ST_P1_COAST_DIV: if (div_done) state_d = sth_pkg::ST_P1_BEST;
			sth_pkg::ST_P1_BEST: state_d = sth_pkg::ST_P1_DIFF;
			sth_pkg::ST_P1_END: state_d = sth_pkg::ST_P1_DEN;
			sth_pkg::ST_P1_DEN: state_d = sth_pkg::ST_P2_DIFF;
			sth_pkg::ST_P2_DIFF: state_d = j_end ? sth_pkg::ST_P2_END : sth_pkg::ST_P2_DIV;
			sth_pkg::ST_P2_DIV: begin
				state_d = (denom_q < sth_pkg::DENOM_MIN) ? sth_pkg::ST_P2_DIFF
				                                         : sth_pkg::ST_P2_WAIT;
			end
			sth_pkg::ST_P2_WAIT: if (div_done) state_d = sth_pkg::ST_P2_DIFF;
			sth_pkg::ST_P2_END: state_d = sth_pkg::ST_ADV;
			sth_pkg::ST_ADV: begin
				if (n_act == '0) begin
					state_d = sth_pkg::ST_IDLE;
				end else if (moving_q && !over) begin
					state_d = sth_pkg::ST_F1;
				end else begin
					state_d = sth_pkg::ST_OUT_PREP;
				end
			end
			sth_pkg::ST_F1: state_d = sth_pkg::ST_F2;
			sth_pkg::ST_F2: state_d = sth_pkg::ST_F3;
			sth_pkg::ST_F3: state_d = sth_pkg::ST_OUT_PREP;
			sth_pkg::ST_OUT_PREP: begin
				state_d = (!done_q && moving_q) ? sth_pkg::ST_PM1 : sth_pkg::ST_OUT;
			end
			sth_pkg::ST_PM1: state_d = sth_pkg::ST_PM2;
			sth_pkg::ST_PM2: state_d = sth_pkg::ST_PM3;
			sth_pkg::ST_PM3: state_d = sth_pkg::ST_OUT;
			sth_pkg::ST_OUT: begin
				if (!out_stall) begin
					state_d = out_last_q ? sth_pkg::ST_IDLE : sth_pkg::ST_OUT_PREP;
				end
			end
			default: state_d = sth_pkg::ST_IDLE;
		endcase
	end

	// unit controls and handshake outputs
	always_comb begin
		mul_a         = '0;
		mul_b         = '0;
		div_req       = '0;
		sq_start      = 1'b0;
		sq_val        = div_quot;
		in_stall      = state_q != sth_pkg::ST_IDLE;
		out_valid     = state_q == sth_pkg::ST_OUT;
		unique case (state_q)
			sth_pkg::ST_P1_MDA: begin
				mul_a = d_abs;
				mul_b = 35'(a_eff);
			end
			sth_pkg::ST_P1_MVV: begin
				mul_a = 32'(v_eff);
				mul_b = 35'(v_eff);
			end
			sth_pkg::ST_P1_MAV: begin
				mul_a = 32'(a_eff);
				mul_b = 35'(v_eff);
			end
			sth_pkg::ST_P1_CMP: begin
				div_req.start = 1'b1;
				div_req.denom = 64'(a_eff);
				if (da_q < vv_q) begin
					div_req.numer = 64'({d_abs, 1'b0});
					div_req.shift = sth_pkg::SHIFT_Q32;
					div_req.cap   = sth_pkg::CAP_U64;
				end else begin
					div_req.numer = 64'(v_eff);
					div_req.shift = sth_pkg::SHIFT_Q16;
					div_req.cap   = sth_pkg::CAP_U32;
				end
			end
			sth_pkg::ST_P1_TRI_DIV: sq_start = div_done;
			sth_pkg::ST_P1_RAMP_DIV: begin
				div_req.start = div_done;
				div_req.numer = da_q - vv_q;
				div_req.shift = sth_pkg::SHIFT_Q16;
				div_req.denom = av_q;
				div_req.cap   = sth_pkg::CAP_U32;
			end
			sth_pkg::ST_P1_END: begin
				mul_a = best_ramp_q;
				mul_b = 35'(33'(best_ramp_q) + 33'(best_coast_q));
			end
			sth_pkg::ST_P2_DIV: begin
				div_req.start = denom_q >= sth_pkg::DENOM_MIN;
				div_req.numer = 64'(d_abs);
				div_req.shift = sth_pkg::SHIFT_Q32;
				div_req.denom = denom_q;
				div_req.cap   = sth_pkg::CAP_S31;
			end
			sth_pkg::ST_F1: begin
				mul_a = ramp_time_q;
				if (in_a) begin
					mul_a = elapsed_q;
					mul_b = 35'(elapsed_q);
				end else if (in_b) begin
					mul_b = 35'({elapsed_q, 1'b0}) - 35'(ramp_time_q);
				end else begin
					mul_b = 35'(ramp_time_q) + 35'({coast_time_q, 1'b0}) + 35'({td, 1'b0});
				end
			end
			sth_pkg::ST_F2: begin
				mul_a = td;
				mul_b = 35'(td);
			end
			sth_pkg::ST_PM1: begin
				mul_a = mag;
				mul_b = 35'(f2_q[31:0]);
			end
			sth_pkg::ST_PM2: begin
				mul_a = mag;
				mul_b = 35'(f2_q[63:32]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sth_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jcnt_q <= sth_pkg::JOINT_COUNT_RST;
			vlim_q <= sth_pkg::SPEED_LIMIT_RST;
			alim_q <= sth_pkg::ACCEL_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (sth_pkg::reg_t'(cfg_index))
				sth_pkg::REG_JOINT_COUNT: jcnt_q <= cfg_data[3:0];
				sth_pkg::REG_SPEED_LIMIT: vlim_q <= cfg_data;
				sth_pkg::REG_ACCEL_LIMIT: alim_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// run control and trajectory state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= sth_pkg::MODE_IDLE;
			moving_q     <= 1'b0;
			holding_q    <= 1'b0;
			done_q       <= 1'b0;
			elapsed_q    <= '0;
			ramp_time_q  <= '0;
			coast_time_q <= '0;
			total_q      <= '0;
			j_q          <= '0;
		end else begin
			unique case (state_q)
				sth_pkg::ST_IDLE: begin
					j_q <= '0;
					if (in_acc) begin
						case (sth_pkg::kind_t'(kind))
							sth_pkg::KIND_START: begin
								if (mode_q != sth_pkg::MODE_RUN) begin
									mode_q    <= sth_pkg::MODE_RUN;
									elapsed_q <= '0;
									moving_q  <= 1'b0;
									holding_q <= 1'b0;
								end
							end
							sth_pkg::KIND_STOP: begin
								if (mode_q == sth_pkg::MODE_RUN) begin
									mode_q    <= sth_pkg::MODE_STOP;
									moving_q  <= 1'b0;
									holding_q <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				sth_pkg::ST_P1_BEST: j_q <= j_q + 1'b1;
				sth_pkg::ST_P1_END: begin
					ramp_time_q  <= best_ramp_q;
					coast_time_q <= best_coast_q;
					total_q      <= (best_q > 34'(sth_pkg::CAP_U32)) ? '1 : best_q[31:0];
				end
				sth_pkg::ST_P1_DEN: j_q <= '0;
				sth_pkg::ST_P2_DIV: begin
					if (denom_q < sth_pkg::DENOM_MIN) j_q <= j_q + 1'b1;
				end
				sth_pkg::ST_P2_WAIT: begin
					if (div_done) j_q <= j_q + 1'b1;
				end
				sth_pkg::ST_P2_END: begin
					elapsed_q <= '0;
					moving_q  <= 1'b1;
				end
				sth_pkg::ST_ADV: begin
					j_q    <= '0;
					done_q <= 1'b0;
					if (moving_q) begin
						if (over) begin
							elapsed_q <= total_q;
							moving_q  <= 1'b0;
							holding_q <= 1'b1;
							done_q    <= 1'b1;
						end else begin
							elapsed_q <= t_next[31:0];
						end
					end
				end
				sth_pkg::ST_OUT: begin
					if (!out_stall) j_q <= j_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// per-joint stores with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < JOINTS_MAX; i++) begin
				start_pos_q[i] <= '0;
				accel_q[i]     <= '0;
				fb_q[i]        <= '0;
			end
		end else begin
			if (state_q == sth_pkg::ST_IDLE && in_acc && joint_ok &&
			    sth_pkg::kind_t'(kind) == sth_pkg::KIND_FEEDBACK) begin
				fb_q[widx] <= position;
			end
			if (state_q == sth_pkg::ST_P1_DIFF && !j_end) begin
				start_pos_q[jidx] <= fb_q[jidx];
			end
			if (state_q == sth_pkg::ST_P2_DIV && denom_q < sth_pkg::DENOM_MIN) begin
				accel_q[jidx] <= '0;
			end
			if (state_q == sth_pkg::ST_P2_WAIT && div_done) begin
				accel_q[jidx] <= diff_q[32] ? 32'(-div_quot[31:0]) : div_quot[31:0];
			end
		end
	end

	// home positions are undefined until written
	always_ff @(posedge clk) begin
		if (state_q == sth_pkg::ST_IDLE && in_acc && joint_ok &&
		    sth_pkg::kind_t'(kind) == sth_pkg::KIND_HOME) begin
			home_q[widx] <= position;
		end
	end

	// planning and profile datapath
	always_ff @(posedge clk) begin
		case (state_q)
			sth_pkg::ST_IDLE: begin
				dt_q         <= tick_time;
				best_q       <= '0;
				best_ramp_q  <= '0;
				best_coast_q <= '0;
			end
			sth_pkg::ST_P1_DIFF: begin
				diff_q <= {home_q[jidx][31], home_q[jidx]} - {fb_q[jidx][31], fb_q[jidx]};
			end
			sth_pkg::ST_P1_MVV: da_q <= prod_q[63:0];
			sth_pkg::ST_P1_MAV: vv_q <= prod_q[63:0];
			sth_pkg::ST_P1_CMP: av_q <= prod_q[63:0];
			sth_pkg::ST_P1_SQRT: begin
				if (sq_done) begin
					ramp_q  <= sq_root;
					coast_q <= '0;
				end
			end
			sth_pkg::ST_P1_RAMP_DIV: begin
				if (div_done) ramp_q <= div_quot[31:0];
			end
			sth_pkg::ST_P1_COAST_DIV: begin
				if (div_done) coast_q <= div_quot[31:0];
			end
			sth_pkg::ST_P1_BEST: begin
				if (local_t > best_q) begin
					best_q       <= local_t;
					best_ramp_q  <= ramp_q;
					best_coast_q <= coast_q;
				end
			end
			sth_pkg::ST_P1_DEN: denom_q <= sth_pkg::sat64(prod_q);
			sth_pkg::ST_P2_DIFF: begin
				diff_q <= {home_q[jidx][31], home_q[jidx]} -
				          {start_pos_q[jidx][31], start_pos_q[jidx]};
			end
			sth_pkg::ST_F2: f2_q <= sth_pkg::sat64(prod_q);
			sth_pkg::ST_F3: begin
				// past the coast segment the decel square comes off unless saturated
				if (!in_a && !in_b && f2_q != sth_pkg::CAP_U64) begin
					f2_q <= f2_q - prod_q[63:0];
				end
			end
			sth_pkg::ST_OUT_PREP: begin
				out_joint_q <= 3'(j_q);
				out_last_q  <= last_j;
				if (done_q) begin
					out_target_q <= home_q[jidx];
				end else if (!moving_q) begin
					out_target_q <= fb_q[jidx];
				end
			end
			sth_pkg::ST_PM2: plo_q <= prod_q[63:0];
			sth_pkg::ST_PM3: out_target_q <= clamped;
			default: begin
			end
		endcase
	end

	assign out_joint       = out_joint_q;
	assign target_position = out_target_q;
	assign last            = out_last_q;

endmodule

FILE: design/sth_div.sv
// shared restoring divider, one quotient bit per cycle, with saturation
module sth_div (
	input  logic               clk,
	input  logic               arst_n,
	input  sth_pkg::div_req_t  req,
	output logic               done,
	output logic [63:0]        quot
);

	localparam int NUM_W = 96;
	localparam int CNT_W = 7;

	logic [NUM_W-1:0] num_q;
	logic [63:0]      rem_q;
	logic [63:0]      q_q;
	logic [63:0]      den_q;
	logic [63:0]      cap_q;
	logic             ovf_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;

	logic [64:0] rem2;
	logic        ge;

	assign rem2 = {rem_q, num_q[NUM_W-1]};
	assign ge   = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= NUM_W'(req.numer) << req.shift;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
			den_q <= req.denom;
			cap_q <= req.cap;
		end else if (busy_q) begin
			rem_q <= ge ? 64'(rem2 - {1'b0, den_q}) : rem2[63:0];
			q_q   <= {q_q[62:0], ge};
			ovf_q <= ovf_q | q_q[63];
			num_q <= num_q << 1;
		end
	end

	assign done = done_q;
	assign quot = (ovf_q || (q_q > cap_q)) ? cap_q : q_q;

endmodule

FILE: design/sth_isqrt.sv
// integer square root of a 64-bit value, two radicand bits per cycle
module sth_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] x_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			r_q   <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q <= x_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[31:0];

endmodule

FILE: design/sth_checker.sv
// port-level checker for the homing trajectory top level, with its bind
module sth_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [2:0]         out_joint,
	input logic signed [31:0] target_position,
	input logic               last
);

	// no new transaction is taken while results are pending
	a_busy_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while results pending");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid)
		else $error("result after last joint");

	a_busy_mid_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> in_stall)
		else $error("block released before last joint");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(target_position) &&
		$stable(out_joint) && $stable(last))
		else $error("stalled result changed");

endmodule

bind synced_trapezoid_homing_top sth_checker u_sth_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.out_joint       (out_joint),
	.target_position (target_position),
	.last            (last)
);

FILE: sim/tb_synced_trapezoid_homing_top.sv
// self-checking testbench of the synchronized trapezoid homing generator
module tb_synced_trapezoid_homing_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int           NJ           = 8;
	localparam int           WATCH_LIMIT  = 60000;
	localparam int           SETTLE_CYC   = 24;
	localparam logic [2:0]   KIND_SPARE5  = 3'd5;
	localparam logic [2:0]   KIND_SPARE6  = 3'd6;
	localparam logic [2:0]   KIND_SPARE7  = 3'd7;
	localparam logic [30:0]  LIMIT_MAX    = 31'h7FFF_FFFF;

	typedef struct {
		logic [2:0]         joint;
		logic signed [31:0] target;
		logic               last;
	} target_t;

	typedef struct {
		logic [2:0]         kind;
		logic [2:0]         jnt;
		logic signed [31:0] pos;
		logic [16:0]        dt;
		bit                 fixed;
		logic signed [31:0] want;
	} stim_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [30:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         kind;
	logic [2:0]         joint;
	logic signed [31:0] position;
	logic [16:0]        tick_time;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         out_joint;
	logic signed [31:0] target_position;
	logic               last;

	synced_trapezoid_homing_top #(.JOINTS_MAX(NJ)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .joint(joint), .position(position), .tick_time(tick_time),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_joint(out_joint), .target_position(target_position), .last(last)
	);

	// predictor state
	logic [3:0]         cf_count;
	logic [30:0]        cf_speed, cf_accel;
	sth_pkg::mode_t     pr_mode;
	bit                 pr_moving, pr_holding;
	logic [31:0]        pr_elapsed, pr_ramp, pr_coast, pr_total;
	logic signed [31:0] pr_start [NJ];
	logic signed [31:0] pr_accel [NJ];
	logic signed [31:0] pr_home  [NJ];
	logic signed [31:0] pr_fb    [NJ];

	target_t expected_targets[$];
	int      errors;
	bit      quiet;
	int      idle_cycles;
	int      stall_left;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	function automatic logic [63:0] div_q(logic [63:0] n, int k, logic [63:0] m,
			logic [63:0] cap);
		logic [63:0] q, r, r2;
		logic        c;
		int          i;
		q = n / m;
		r = n % m;
		if (q > cap) return cap;
		for (i = 0; i < k; i++) begin
			c = r[63];
			r2 = r << 1;
			if (q > (cap >> 1)) return cap;
			q = q << 1;
			if (c || r2 >= m) begin
				q[0] = 1'b1;
				r = r2 - m;
			end else begin
				r = r2;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] root64(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] mul_sat(logic [63:0] x, logic [63:0] y);
		logic [127:0] p;
		p = {64'd0, x} * {64'd0, y};
		return (p[127:64] != 0) ? sth_pkg::CAP_U64 : p[63:0];
	endfunction

	task automatic plan_move(int n);
		logic [63:0] v, a, best, best_ramp, best_coast, den, d, ramp, coast, loc, mag;
		longint      diff;
		int          j;
		v = (cf_speed != 0) ? 64'(cf_speed) : 64'd1;
		a = (cf_accel != 0) ? 64'(cf_accel) : 64'd1;
		best = 0;
		best_ramp = 0;
		best_coast = 0;
		for (j = 0; j < n; j++) begin
			pr_start[j] = pr_fb[j];
			diff = longint'(pr_home[j]) - longint'(pr_start[j]);
			d = (diff < 0) ? -diff : diff;
			if (d * a < v * v) begin
				ramp = root64(div_q(2 * d, 32, a, sth_pkg::CAP_U64));
				coast = 0;
			end else begin
				ramp = div_q(v, 16, a, sth_pkg::CAP_U32);
				coast = div_q(d * a - v * v, 16, a * v, sth_pkg::CAP_U32);
			end
			loc = 2 * ramp + coast;
			if (loc > best) begin
				best = loc;
				best_ramp = ramp;
				best_coast = coast;
			end
		end
		pr_ramp = best_ramp[31:0];
		pr_coast = best_coast[31:0];
		pr_total = (best > sth_pkg::CAP_U32) ? 32'hFFFF_FFFF : best[31:0];
		den = mul_sat(best_ramp, best_ramp + best_coast);
		for (j = 0; j < n; j++) begin
			diff = longint'(pr_home[j]) - longint'(pr_start[j]);
			d = (diff < 0) ? -diff : diff;
			if (den < sth_pkg::DENOM_MIN) begin
				pr_accel[j] = 0;
			end else begin
				mag = div_q(d, 32, den, sth_pkg::CAP_S31);
				pr_accel[j] = (diff < 0) ? -$signed(mag[31:0]) : $signed(mag[31:0]);
			end
		end
		pr_elapsed = 0;
		pr_moving = 1;
	endtask

	function automatic logic signed [31:0] profile_at(int j);
		logic [63:0] t, t1, t2, td, f2, mag, p_lo, p_hi, off;
		longint      acc, res;
		t = 64'(pr_elapsed);
		t1 = 64'(pr_ramp);
		t2 = t1 + 64'(pr_coast);
		if (t <= t1) begin
			f2 = t * t;
		end else if (t <= t2) begin
			f2 = mul_sat(t1, 2 * t - t1);
		end else begin
			td = t - t2;
			f2 = mul_sat(t1, t1 + 2 * 64'(pr_coast) + 2 * td);
			if (f2 != sth_pkg::CAP_U64) f2 = f2 - td * td;
		end
		acc = longint'(pr_accel[j]);
		mag = (acc < 0) ? -acc : acc;
		p_lo = mag * (f2 & sth_pkg::CAP_U32);
		p_hi = mag * (f2 >> 32);
		off = (p_hi >> 1) + ((((p_hi & 64'd1) << 32) + p_lo) >> 33);
		res = longint'(pr_start[j]) + ((acc < 0) ? -longint'(off) : longint'(off));
		if (res > 64'sh7FFF_FFFF) res = 64'sh7FFF_FFFF;
		if (res < -64'sh8000_0000) res = -64'sh8000_0000;
		return res[31:0];
	endfunction

	task automatic predict_item(logic [2:0] k, logic [2:0] jn, logic signed [31:0] p,
			logic [16:0] dt);
		int          n, j;
		bit          done;
		logic [63:0] t;
		target_t     e;
		done = 0;
		case (k)
			sth_pkg::KIND_FEEDBACK: pr_fb[jn] = p;
			sth_pkg::KIND_HOME:     pr_home[jn] = p;
			sth_pkg::KIND_START: begin
				if (pr_mode != sth_pkg::MODE_RUN) begin
					pr_mode = sth_pkg::MODE_RUN;
					pr_elapsed = 0;
					pr_moving = 0;
					pr_holding = 0;
				end
			end
			sth_pkg::KIND_STOP: begin
				if (pr_mode == sth_pkg::MODE_RUN) begin
					pr_mode = sth_pkg::MODE_STOP;
					pr_moving = 0;
					pr_holding = 0;
				end
			end
			sth_pkg::KIND_TICK: begin
				if (pr_mode == sth_pkg::MODE_RUN) begin
					n = (cf_count < NJ) ? int'(cf_count) : NJ;
					if (!pr_moving && !pr_holding) plan_move(n);
					if (pr_moving) begin
						t = 64'(pr_elapsed) + 64'(dt);
						if (t > 64'(pr_total)) begin
							t = 64'(pr_total);
							pr_moving = 0;
							pr_holding = 1;
							done = 1;
						end
						pr_elapsed = t[31:0];
					end
					for (j = 0; j < n; j++) begin
						e.joint = j[2:0];
						e.last = (j + 1 == n);
						if (done) e.target = pr_home[j];
						else if (pr_moving) e.target = profile_at(j);
						else e.target = pr_fb[j];
						expected_targets.push_back(e);
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic signed [31:0] pick_pos();
		if ($urandom_range(0, 1) == 0) return $signed($urandom_range(0, 131072)) - 65536;
		return $urandom;
	endfunction

	function automatic logic [16:0] pick_dt();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 17'd65536;
		if (r < 4) return 17'($urandom_range(0, 65536));
		return 17'($urandom_range(0, 4096));
	endfunction

	// one input transaction; in_valid stays high when the next one follows at once
	task automatic send_item(logic [2:0] k, logic [2:0] jn, logic signed [31:0] p,
			logic [16:0] dt, bit fixed, logic signed [31:0] want);
		int gap, before_n;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		joint <= jn;
		position <= p;
		tick_time <= dt;
		do @(posedge clk); while (in_stall);
		before_n = expected_targets.size();
		predict_item(k, jn, p, dt);
		if (fixed && expected_targets.size() > before_n)
			expected_targets[before_n].target = want;
	endtask

	task automatic write_reg(sth_pkg::reg_t idx, logic [30:0] val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_targets.size() != 0 || in_stall) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sth_pkg::REG_JOINT_COUNT: cf_count = val[3:0];
			sth_pkg::REG_SPEED_LIMIT: cf_speed = val;
			sth_pkg::REG_ACCEL_LIMIT: cf_accel = val;
			default: ;
		endcase
	endtask

	// result checking
	always @(posedge clk) begin : check_results
		target_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_targets.size() == 0) begin
				report("unexpected result joint", out_joint, -1);
			end else begin
				e = expected_targets.pop_front();
				if (out_joint !== e.joint) report("out_joint", out_joint, e.joint);
				if (target_position !== e.target)
					report("target_position", target_position, e.target);
				if (last !== e.last) report("last", last, e.last);
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (!arst_n || quiet) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < 25) begin
			out_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
				: $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCH_LIMIT) begin
			$display("tb_synced_trapezoid_homing_top failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	stim_t dir_tab [22];

	initial begin : main
		int i, p, r, k;
		errors = 0;
		quiet = 0;
		idle_cycles = 0;
		stall_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = '0;
		joint = '0;
		position = '0;
		tick_time = '0;
		cf_count = sth_pkg::JOINT_COUNT_RST;
		cf_speed = sth_pkg::SPEED_LIMIT_RST;
		cf_accel = sth_pkg::ACCEL_LIMIT_RST;
		pr_mode = sth_pkg::MODE_IDLE;
		pr_moving = 0;
		pr_holding = 0;
		pr_elapsed = 0;
		pr_ramp = 0;
		pr_coast = 0;
		pr_total = 0;
		for (i = 0; i < NJ; i++) begin
			pr_start[i] = 0;
			pr_accel[i] = 0;
			pr_home[i] = 0;
			pr_fb[i] = 0;
		end
		// small homes with default limits: a full-second tick finishes the move
		dir_tab = '{
			'{sth_pkg::KIND_HOME, 3'd0, 32'sd256, 17'd0, 0, 0},
			'{sth_pkg::KIND_HOME, 3'd1, 32'sd512, 17'd0, 0, 0},
			'{sth_pkg::KIND_HOME, 3'd2, 32'sd768, 17'd0, 0, 0},
			'{sth_pkg::KIND_HOME, 3'd3, 32'sd1024, 17'd0, 0, 0},
			'{sth_pkg::KIND_HOME, 3'd4, 32'sd1280, 17'd0, 0, 0},
			'{sth_pkg::KIND_HOME, 3'd5, 32'sd1536, 17'd0, 0, 0},
			'{sth_pkg::KIND_HOME, 3'd6, 32'sd1792, 17'd0, 0, 0},
			'{sth_pkg::KIND_HOME, 3'd7, -32'sd2048, 17'd0, 0, 0},
			'{sth_pkg::KIND_TICK, 3'd0, 32'sd0, 17'd100, 0, 0},
			'{sth_pkg::KIND_STOP, 3'd0, 32'sd0, 17'd0, 0, 0},
			'{KIND_SPARE5, 3'd0, 32'sd0, 17'd0, 0, 0},
			'{sth_pkg::KIND_START, 3'd0, 32'sd0, 17'd0, 0, 0},
			'{sth_pkg::KIND_TICK, 3'd0, 32'sd0, 17'd65536, 1, 32'sd256},
			'{sth_pkg::KIND_TICK, 3'd0, 32'sd0, 17'd0, 1, 32'sd0},
			'{sth_pkg::KIND_START, 3'd0, 32'sd0, 17'd0, 0, 0},
			'{sth_pkg::KIND_STOP, 3'd0, 32'sd0, 17'd0, 0, 0},
			'{sth_pkg::KIND_START, 3'd0, 32'sd0, 17'd0, 0, 0},
			'{sth_pkg::KIND_TICK, 3'd0, 32'sd0, 17'd0, 1, 32'sd0},
			'{sth_pkg::KIND_TICK, 3'd0, 32'sd0, 17'd1000, 0, 0},
			'{sth_pkg::KIND_FEEDBACK, 3'd0, 32'sh7FFF_FFFF, 17'd0, 0, 0},
			'{sth_pkg::KIND_FEEDBACK, 3'd1, -32'sh8000_0000, 17'd0, 0, 0},
			'{KIND_SPARE7, 3'd7, -32'sd1, 17'h1FFFF, 0, 0}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i])
			send_item(dir_tab[i].kind, dir_tab[i].jnt, dir_tab[i].pos, dir_tab[i].dt,
				dir_tab[i].fixed, dir_tab[i].want);

		for (p = 0; p < 6; p++) begin
			quiet = (p == 3);
			case (p)
				0: begin
					write_reg(sth_pkg::REG_JOINT_COUNT, 31'd1);
					write_reg(sth_pkg::REG_SPEED_LIMIT, LIMIT_MAX);
					write_reg(sth_pkg::REG_ACCEL_LIMIT, LIMIT_MAX);
				end
				1: begin
					write_reg(sth_pkg::REG_JOINT_COUNT, 31'd0);
					write_reg(sth_pkg::REG_SPEED_LIMIT, 31'd0);
					write_reg(sth_pkg::REG_ACCEL_LIMIT, 31'd0);
				end
				2: begin
					write_reg(sth_pkg::REG_JOINT_COUNT, 31'd15);
					write_reg(sth_pkg::REG_SPEED_LIMIT,
						31'($urandom_range(1 << 12, 1 << 22)));
					write_reg(sth_pkg::REG_ACCEL_LIMIT,
						31'($urandom_range(1 << 12, 1 << 24)));
				end
				default: begin
					write_reg(sth_pkg::REG_JOINT_COUNT, 31'($urandom_range(1, 8)));
					write_reg(sth_pkg::REG_SPEED_LIMIT, ($urandom_range(0, 3) == 0) ?
						LIMIT_MAX : 31'($urandom_range(1 << 14, 1 << 24)));
					write_reg(sth_pkg::REG_ACCEL_LIMIT, ($urandom_range(0, 3) == 0) ?
						31'd1 : 31'($urandom_range(1 << 14, 1 << 26)));
				end
			endcase
			// well-formed run: stop, fresh feedback, start, then mostly ticks
			send_item(sth_pkg::KIND_STOP, 3'd0, 32'sd0, 17'd0, 1'b0, 32'sd0);
			for (i = 0; i < 4; i++)
				send_item(sth_pkg::KIND_FEEDBACK, 3'($urandom_range(0, 7)), pick_pos(),
					17'd0, 1'b0, 32'sd0);
			send_item(sth_pkg::KIND_START, 3'($urandom), $urandom, 17'($urandom),
				1'b0, 32'sd0);
			for (i = 0; i < 19; i++) begin
				r = $urandom_range(0, 99);
				if (r < 68)
					send_item(sth_pkg::KIND_TICK, 3'($urandom), $urandom, pick_dt(),
						1'b0, 32'sd0);
				else if (r < 78)
					send_item(sth_pkg::KIND_FEEDBACK, 3'($urandom_range(0, 7)),
						pick_pos(), 17'd0, 1'b0, 32'sd0);
				else if (r < 84)
					send_item(sth_pkg::KIND_HOME, 3'($urandom_range(0, 7)),
						pick_pos(), 17'd0, 1'b0, 32'sd0);
				else if (r < 89)
					send_item(sth_pkg::KIND_STOP, 3'($urandom), $urandom, 17'd0,
						1'b0, 32'sd0);
				else if (r < 95)
					send_item(sth_pkg::KIND_START, 3'($urandom), $urandom, 17'd0,
						1'b0, 32'sd0);
				else begin
					k = $urandom_range(5, 7);
					send_item(k[2:0], 3'($urandom), $urandom, 17'($urandom),
						1'b0, 32'sd0);
				end
			end
		end
		quiet = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_targets.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (errors == 0 && expected_targets.size() == 0) begin
			$display("tb_synced_trapezoid_homing_top passed");
		end else begin
			$display("tb_synced_trapezoid_homing_top failed");
		end
		$finish;
	end

endmodule
